// ----- sv/bezier_segment_distance_sampler_assert.svh -----
// Assertion macros for the Bezier segment sampler.
// Used by modules that clock on clk and reset on rst.
`ifndef BEZIER_SEGMENT_DISTANCE_SAMPLER_ASSERT_SVH
`define BEZIER_SEGMENT_DISTANCE_SAMPLER_ASSERT_SVH

// same-cycle implication
`define BSDS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSDS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bsds_pkg.sv -----
// Shared types and constants for the Bezier segment sampler.
// No dependencies.
package bsds_pkg;

  localparam int LENGTH_STEPS_DEF = 16;
  localparam int MAX_STEPS_DEF    = 63;
  localparam int CNT_W            = 7;
  localparam int W_W              = 19;
  localparam int SQ_W             = 13;
  localparam int ACC_W            = 51;
  localparam int LEN_W            = 40;
  localparam int ROOT_W           = 33;
  localparam logic [31:0] SPACING_RST = 32'd65536;
  localparam logic [31:0] SIGN32      = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] ctrl1_x;
    logic signed [31:0] ctrl1_y;
    logic signed [31:0] ctrl2_x;
    logic signed [31:0] ctrl2_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               is_first;
  } seg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last;
    logic               clipped;
  } pt_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MM, S_KK, S_W0, S_W1, S_W2, S_W3, S_ACC, S_DIVGO, S_DIVW,
    S_SQX, S_SQY, S_RGO, S_RW, S_NGO, S_NW, S_OUT
  } state_t;

endpackage

// ----- sv/bezier_segment_distance_sampler.sv -----
// Channel  | Dir | Handshake          | Word
// seg      | in  | seg_valid/stall    | seg_t: four control points, first flag
// pt       | out | pt_valid/stall     | pt_t: curve point, last, clipped
// cfg      | in  | cfg_valid/ready    | 32-bit spacing, unsigned Q16.16
// One segment at a time; seg_stall stays high from acceptance to the last point.
// A curve evaluation is dominated by two 32-step divides.
// Per segment: LENGTH_STEPS+1 curve evaluations measure the length, then one
// evaluation per emitted point, each point held while pt_stall is high.
// rst is synchronous; spacing resets to 1.0 m. Depends on bsds_pkg, bsds_div, bsds_sqrt.
`include "bezier_segment_distance_sampler_assert.svh"

module bezier_segment_distance_sampler #(
  parameter int LENGTH_STEPS = bsds_pkg::LENGTH_STEPS_DEF,
  parameter int MAX_STEPS    = bsds_pkg::MAX_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_valid,
  output logic           seg_stall,
  input  bsds_pkg::seg_t seg,
  output logic           pt_valid,
  input  logic           pt_stall,
  output bsds_pkg::pt_t  pt,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import bsds_pkg::*;

  localparam int LS_C  = (LENGTH_STEPS < 1) ? 1 : ((LENGTH_STEPS > 64) ? 64 : LENGTH_STEPS);
  localparam int CAP_C = (MAX_STEPS < 1) ? 1 : ((MAX_STEPS > 63) ? 63 : MAX_STEPS);
  localparam logic [CNT_W-1:0] LS_N  = CNT_W'(LS_C);
  localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP_C);

  state_t state, state_next;

  logic [31:0]       spacing, sp;
  logic [31:0]       cx [4];
  logic [31:0]       cy [4];
  logic              first, emit, ax, clip;
  logic [CNT_W-1:0]  k, n, m;
  logic [CNT_W+1:0]  k3, m3;
  logic [SQ_W-1:0]   mm, kk;
  logic [W_W-1:0]    w [4];
  logic [W_W-1:0]    d;
  logic [2:0]        j;
  logic [63:0]       p, sqx, sqy;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  len;
  logic [31:0]       qx, qy, px, py, dx, dy;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic              div_start, div_long, div_done;
  logic [63:0]       div_dividend, div_q;
  logic [31:0]       div_divisor;
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  assign m     = n - k;
  assign k3    = {1'b0, k, 1'b0} + (CNT_W+2)'(k);
  assign m3    = {1'b0, m, 1'b0} + (CNT_W+2)'(m);
  assign d     = w[0] + w[1] + w[2] + w[3];
  assign sp    = (spacing == '0) ? 32'd1 : spacing;
  assign dx    = (qx >= px) ? qx - px : px - qx;
  assign dy    = (qy >= py) ? qy - py : py - qy;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign seg_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  bsds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .long_mode (div_long),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quot      (div_q)
  );

  bsds_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (66'(sqx) + 66'(sqy)),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (seg_valid) state_next = S_MM;
      S_MM:    state_next = S_KK;
      S_KK:    state_next = S_W0;
      S_W0:    state_next = S_W1;
      S_W1:    state_next = S_W2;
      S_W2:    state_next = S_W3;
      S_W3:    state_next = S_ACC;
      S_ACC:   if (j == 3'd4) state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          if (!ax) state_next = S_ACC;
          else if (emit) state_next = S_OUT;
          else if (k == '0) state_next = S_MM;
          else state_next = S_SQX;
        end
      end
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_RGO;
      S_RGO:   state_next = S_RW;
      S_RW: begin
        if (sq_done) state_next = (k == n) ? S_NGO : S_MM;
      end
      S_NGO:   state_next = S_NW;
      S_NW:    if (div_done) state_next = S_MM;
      S_OUT: begin
        if (!pt_stall) state_next = (k == n) ? S_IDLE : S_MM;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_long     = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sq_start     = 1'b0;
    case (state)
      S_MM: begin
        mul_a = 32'(m);
        mul_b = 32'(m);
      end
      S_KK: begin
        mul_a = 32'(k);
        mul_b = 32'(k);
      end
      S_W0: begin
        mul_a = 32'(mm);
        mul_b = 32'(m);
      end
      S_W1: begin
        mul_a = 32'(mm);
        mul_b = 32'(k3);
      end
      S_W2: begin
        mul_a = 32'(kk);
        mul_b = 32'(m3);
      end
      S_W3: begin
        mul_a = 32'(kk);
        mul_b = 32'(k);
      end
      S_ACC: begin
        mul_a = ax ? cy[j[1:0]] : cx[j[1:0]];
        mul_b = 32'(w[j[1:0]]);
      end
      S_DIVGO: begin
        div_start    = 1'b1;
        div_dividend = 64'(acc) + 64'(d >> 1);
        div_divisor  = 32'(d);
      end
      S_SQX: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      S_RGO: sq_start = 1'b1;
      S_NGO: begin
        div_start    = 1'b1;
        div_long     = 1'b1;
        div_dividend = 64'(len) + 64'(sp) - 64'd1;
        div_divisor  = sp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pt_valid <= 1'b0;
      spacing  <= SPACING_RST;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        spacing <= cfg_data;
      end
      if (state == S_DIVW && div_done && ax && emit) begin
        pt_valid <= 1'b1;
      end else if (state == S_OUT && !pt_stall) begin
        pt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j <= '0;
    case (state)
      S_IDLE: begin
        if (seg_valid) begin
          cx[0] <= seg.start_x ^ SIGN32;
          cy[0] <= seg.start_y ^ SIGN32;
          cx[1] <= seg.ctrl1_x ^ SIGN32;
          cy[1] <= seg.ctrl1_y ^ SIGN32;
          cx[2] <= seg.ctrl2_x ^ SIGN32;
          cy[2] <= seg.ctrl2_y ^ SIGN32;
          cx[3] <= seg.end_x ^ SIGN32;
          cy[3] <= seg.end_y ^ SIGN32;
          first <= seg.is_first;
          k     <= '0;
          n     <= LS_N;
          len   <= '0;
          emit  <= 1'b0;
          ax    <= 1'b0;
          clip  <= 1'b0;
        end
      end
      S_MM: mm <= SQ_W'(mul_p);
      S_KK: kk <= SQ_W'(mul_p);
      S_W0: w[0] <= W_W'(mul_p);
      S_W1: w[1] <= W_W'(mul_p);
      S_W2: w[2] <= W_W'(mul_p);
      S_W3: w[3] <= W_W'(mul_p);
      S_ACC: begin
        if (j != 3'd4) p <= mul_p;
        acc <= (j == '0) ? '0 : acc + ACC_W'(p);
        j   <= j + 3'd1;
      end
      S_DIVW: begin
        if (div_done) begin
          if (!ax) begin
            qx <= div_q[31:0];
            ax <= 1'b1;
          end else begin
            ax <= 1'b0;
            if (emit) begin
              pt.point_x <= qx ^ SIGN32;
              pt.point_y <= div_q[31:0] ^ SIGN32;
              pt.last    <= (k == n);
              pt.clipped <= clip;
            end else if (k == '0) begin
              px <= qx;
              py <= div_q[31:0];
              k  <= k + 1'b1;
            end else begin
              qy <= div_q[31:0];
            end
          end
        end
      end
      S_SQX: sqx <= mul_p;
      S_SQY: sqy <= mul_p;
      S_RW: begin
        if (sq_done) begin
          len <= len + LEN_W'(sq_root);
          px  <= qx;
          py  <= qy;
          if (k != n) k <= k + 1'b1;
        end
      end
      S_NW: begin
        if (div_done) begin
          if (div_q == '0) begin
            n <= CNT_W'(1);
          end else if (div_q > 64'(CAP_N)) begin
            n    <= CAP_N;
            clip <= 1'b1;
          end else begin
            n <= div_q[CNT_W-1:0];
          end
          k    <= first ? CNT_W'(0) : CNT_W'(1);
          emit <= 1'b1;
        end
      end
      S_OUT: begin
        if (!pt_stall && k != n) k <= k + 1'b1;
      end
      default: ;
    endcase
  end

  `BSDS_IMPLY(a_ready_no_word, !seg_stall, !pt_valid, "ready while a point is pending")
  `BSDS_NEXT(a_last_frees, pt_valid && !pt_stall && pt.last, !seg_stall, "not ready after last")
  `BSDS_NEXT(a_take_busy, seg_valid && !seg_stall, seg_stall && !pt_valid, "segment take not busy")
  `BSDS_IMPLY(a_one_unit, div_done || sq_done, !(div_done && sq_done), "divider and root overlap")
  `BSDS_IMPLY(a_k_bound, seg_stall, k <= n, "sample index past count")

endmodule

// ----- sv/bsds_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Short mode runs 32 steps when the quotient is known to fit 32 bits.
// Depends on bsds_pkg.
module bsds_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        long_mode,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);
  import bsds_pkg::*;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [63:0] q;
  logic [6:0]  cnt;
  logic [32:0] t;
  logic        ge;

  assign t  = {rem, q[63]};
  assign ge = t >= {1'b0, dvs};
  assign quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= long_mode ? 7'd64 : 7'd32;
      end else if (cnt != '0) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      if (long_mode) begin
        rem <= '0;
        q   <= dividend;
      end else begin
        rem <= dividend[63:32];
        q   <= {dividend[31:0], 32'd0};
      end
    end else if (cnt != '0) begin
      rem <= ge ? 32'(t - {1'b0, dvs}) : t[31:0];
      q   <= {q[62:0], ge};
    end
  end

endmodule

// ----- sv/bsds_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on bsds_pkg.
module bsds_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [65:0]                  radicand,
  output logic                         done,
  output logic [bsds_pkg::ROOT_W-1:0]  root
);
  import bsds_pkg::*;

  logic [65:0]       rad;
  logic [34:0]       rem;
  logic [5:0]        cnt;
  logic [36:0]       t;
  logic [34:0]       trial;
  logic              ge;

  assign t     = {rem, rad[65:64]};
  assign trial = {root, 2'b01};
  assign ge    = t >= 37'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd33;
      end else if (cnt != '0) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      rad  <= {rad[63:0], 2'b00};
      rem  <= ge ? 35'(t - 37'(trial)) : 35'(t);
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule
